### hdl/assert_macros.svh
// assertion macros used by the codec top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### hdl/mbc_pkg.sv
// types, constants and symbol table of the morse byte codec
`timescale 1ns / 1ps

package mbc_pkg;

    localparam int MAX_CODE_LEN_DEF = 6;
    localparam int CODE_LEN_W       = 3;
    localparam int CODE_PAT_W       = 6;
    localparam int TABLE_SIZE       = 40;
    localparam int QUEUE_DEPTH      = 4;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic REG_IDX_MODE = 1'b0;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]            ch;
        logic [CODE_LEN_W-1:0] len;
        logic [CODE_PAT_W-1:0] pat;
    } t_sym;

    typedef struct packed {
        logic                  found;
        logic [CODE_LEN_W-1:0] len;
        logic [CODE_PAT_W-1:0] pat;
    } t_enc;

    // one unit of work for the emitter: a character, or a code with optional separator
    typedef struct packed {
        logic                  is_char;
        logic                  sep;
        logic [CODE_LEN_W-1:0] len;
        logic [CODE_PAT_W-1:0] pat;
        logic [7:0]            ch;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // pattern bit k set when element k is a dash
    localparam t_sym SYM_TABLE [TABLE_SIZE] = '{
        '{"A", 3'd2, 6'b000010}, '{"J", 3'd4, 6'b001110}, '{"S", 3'd3, 6'b000000},
        '{"2", 3'd5, 6'b011100}, '{"B", 3'd4, 6'b000001}, '{"K", 3'd3, 6'b000101},
        '{"T", 3'd1, 6'b000001}, '{"3", 3'd5, 6'b011000}, '{"C", 3'd4, 6'b000101},
        '{"L", 3'd4, 6'b000010}, '{"U", 3'd3, 6'b000100}, '{"4", 3'd5, 6'b010000},
        '{"D", 3'd3, 6'b000001}, '{"M", 3'd2, 6'b000011}, '{"V", 3'd4, 6'b001000},
        '{"5", 3'd5, 6'b000000}, '{"E", 3'd1, 6'b000000}, '{"N", 3'd2, 6'b000001},
        '{"W", 3'd3, 6'b000110}, '{"6", 3'd5, 6'b000001}, '{"F", 3'd4, 6'b000100},
        '{"O", 3'd3, 6'b000111}, '{"X", 3'd4, 6'b001001}, '{"7", 3'd5, 6'b000011},
        '{"G", 3'd3, 6'b000011}, '{"P", 3'd4, 6'b000110}, '{"Y", 3'd4, 6'b001101},
        '{"8", 3'd5, 6'b000111}, '{"H", 3'd4, 6'b000000}, '{"Q", 3'd4, 6'b001011},
        '{"Z", 3'd4, 6'b000011}, '{"9", 3'd5, 6'b001111}, '{"I", 3'd2, 6'b000000},
        '{"R", 3'd3, 6'b000010}, '{"1", 3'd5, 6'b011110}, '{"0", 3'd5, 6'b011111},
        '{" ", 3'd5, 6'b010001}, '{"?", 3'd6, 6'b001100}, '{"!", 3'd6, 6'b110011},
        '{",", 3'd6, 6'b101010}
    };

    // text byte to code, lower case folded to upper case
    function automatic t_enc enc_lookup(input logic [7:0] b);
        logic [7:0] u;
        t_enc       res;
        u   = (b >= CH_LO_A && b <= CH_LO_Z) ? (b - CASE_OFS) : b;
        res = '0;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (SYM_TABLE[i].ch == u) begin
                res.found = 1'b1;
                res.len   = SYM_TABLE[i].len;
                res.pat   = SYM_TABLE[i].pat;
            end
        end
        return res;
    endfunction

    // code to character, lowest table entry wins, no match gives plus
    function automatic logic [7:0] dec_lookup(input logic [3:0] len,
                                              input logic [CODE_PAT_W-1:0] pat);
        logic [7:0] res;
        res = CH_PLUS;
        for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if ({1'b0, SYM_TABLE[i].len} == len && SYM_TABLE[i].pat == pat) begin
                res = SYM_TABLE[i].ch;
            end
        end
        return res;
    endfunction

endpackage

### hdl/mbc_front.sv
// front end: accepts bytes, tracks message state, builds emitter jobs
`timescale 1ns / 1ps

module mbc_front #(
    parameter int MAX_CODE_LEN = mbc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_mode,
    input  logic                i_clear,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mbc_pkg::t_in_word   i_in_word,
    input  mbc_pkg::t_q_status  i_qstat,
    output logic                o_push,
    output mbc_pkg::t_job       o_job
);

    localparam int LEN_W = $clog2(MAX_CODE_LEN + 2);
    localparam int PAT_W = MAX_CODE_LEN;

    logic             r_emitted, n_emitted;
    logic [LEN_W-1:0] r_len, n_len;
    logic [PAT_W-1:0] r_pat, n_pat;
    logic             r_inv, n_inv;
    logic             r_absorb, n_absorb;

    logic             accept;
    logic [7:0]       b;
    logic             eom;
    logic             is_space;
    logic [LEN_W-1:0] ext_len;
    logic [PAT_W-1:0] ext_pat;
    logic             ext_inv;
    logic [LEN_W-1:0] dec_len;
    logic [PAT_W-1:0] dec_pat;
    logic             dec_inv;
    logic [7:0]       dec_ch;
    mbc_pkg::t_enc    enc;

    assign o_in_ready = !i_qstat.full;

    always_comb begin
        accept   = i_in_valid && o_in_ready;
        b        = i_in_word.in_byte;
        eom      = i_in_word.end_of_message;
        is_space = (b == mbc_pkg::CH_SPACE);

        // token as it stands after this byte joins it
        ext_len = r_len + LEN_W'(1);
        ext_pat = r_pat;
        if (b == mbc_pkg::CH_DASH && r_len < LEN_W'(MAX_CODE_LEN)) begin
            ext_pat = r_pat | (PAT_W'(1) << r_len);
        end
        ext_inv = r_inv || !(b == mbc_pkg::CH_DOT || b == mbc_pkg::CH_DASH);

        // a space closes the token as it was, anything else closes the grown one
        dec_len = is_space ? r_len : ext_len;
        dec_pat = is_space ? r_pat : ext_pat;
        dec_inv = is_space ? r_inv : ext_inv;
        if (dec_inv || dec_len == '0 || dec_len > LEN_W'(MAX_CODE_LEN)) begin
            dec_ch = mbc_pkg::CH_PLUS;
        end else begin
            dec_ch = mbc_pkg::dec_lookup(4'(dec_len), mbc_pkg::CODE_PAT_W'(dec_pat));
        end

        enc = mbc_pkg::enc_lookup(b);

        n_emitted = r_emitted;
        n_len     = r_len;
        n_pat     = r_pat;
        n_inv     = r_inv;
        n_absorb  = r_absorb;
        o_push    = 1'b0;
        o_job     = '0;

        if (accept) begin
            if (i_mode == mbc_pkg::MODE_ENCODE) begin
                if (enc.found) begin
                    o_push     = 1'b1;
                    o_job.sep  = r_emitted;
                    o_job.len  = enc.len;
                    o_job.pat  = enc.pat;
                    n_emitted  = 1'b1;
                end
            end else if (r_absorb && is_space) begin
                n_absorb = 1'b0;
            end else begin
                n_absorb = 1'b0;
                if (is_space) begin
                    o_push        = 1'b1;
                    o_job.is_char = 1'b1;
                    o_job.ch      = dec_ch;
                    n_len         = '0;
                    n_pat         = '0;
                    n_inv         = 1'b0;
                end else begin
                    n_len = ext_len;
                    n_pat = ext_pat;
                    n_inv = ext_inv;
                    if (ext_len >= LEN_W'(MAX_CODE_LEN + 1) || eom) begin
                        o_push        = 1'b1;
                        o_job.is_char = 1'b1;
                        o_job.ch      = dec_ch;
                        n_len         = '0;
                        n_pat         = '0;
                        n_inv         = 1'b0;
                        n_absorb      = (ext_len >= LEN_W'(MAX_CODE_LEN + 1));
                    end
                end
            end
            if (eom) begin
                n_emitted = 1'b0;
                n_len     = '0;
                n_pat     = '0;
                n_inv     = 1'b0;
                n_absorb  = 1'b0;
            end
        end

        if (i_clear) begin
            n_emitted = 1'b0;
            n_len     = '0;
            n_pat     = '0;
            n_inv     = 1'b0;
            n_absorb  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emitted <= 1'b0;
            r_len     <= '0;
            r_pat     <= '0;
            r_inv     <= 1'b0;
            r_absorb  <= 1'b0;
        end else begin
            r_emitted <= n_emitted;
            r_len     <= n_len;
            r_pat     <= n_pat;
            r_inv     <= n_inv;
            r_absorb  <= n_absorb;
        end
    end

endmodule

### hdl/mbc_queue.sv
// small job queue between front end and emitter
`timescale 1ns / 1ps

module mbc_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mbc_pkg::t_job       i_job,
    input  logic                i_pop,
    output mbc_pkg::t_job       o_head,
    output mbc_pkg::t_q_status  o_stat
);

    localparam int DEPTH = mbc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbc_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    always_comb begin
        o_stat.full  = (r_count == CNT_W'(DEPTH));
        o_stat.empty = (r_count == '0);
        o_head       = r_mem[r_rd_ptr];

        n_wr_ptr = i_push ? r_wr_ptr + PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### hdl/mbc_back.sv
// emitter: turns jobs into registered output bytes, one per cycle unless stalled
`timescale 1ns / 1ps

module mbc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbc_pkg::t_job       i_head,
    input  mbc_pkg::t_q_status  i_qstat,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mbc_pkg::t_out_word  o_out_word
);

    localparam int STEP_W = mbc_pkg::CODE_LEN_W;

    logic                  r_active, n_active;
    mbc_pkg::t_job         r_job, n_job;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    mbc_pkg::t_out_word    r_out_word, n_out_word;

    logic                  can_emit;
    logic [STEP_W-1:0]     total;
    logic                  last;
    logic [STEP_W-1:0]     elt;
    logic [mbc_pkg::CODE_PAT_W-1:0] pat_sh;
    logic [7:0]            cur_byte;

    always_comb begin
        can_emit = !r_out_valid || i_out_ready;
        total    = r_job.is_char ? STEP_W'(1) : r_job.len + STEP_W'(r_job.sep);
        last     = (r_step == total - STEP_W'(1));
        elt      = r_step - STEP_W'(r_job.sep);
        pat_sh   = r_job.pat >> elt;

        if (r_job.is_char) begin
            cur_byte = r_job.ch;
        end else if (r_job.sep && r_step == '0) begin
            cur_byte = mbc_pkg::CH_SPACE;
        end else if (pat_sh[0]) begin
            cur_byte = mbc_pkg::CH_DASH;
        end else begin
            cur_byte = mbc_pkg::CH_DOT;
        end

        n_active    = r_active;
        n_job       = r_job;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        o_pop       = 1'b0;

        if (r_active && can_emit) begin
            n_out_valid         = 1'b1;
            n_out_word.out_byte = cur_byte;
            n_out_word.run_last = last;
            if (last) begin
                if (!i_qstat.empty) begin
                    o_pop  = 1'b1;
                    n_job  = i_head;
                    n_step = '0;
                end else begin
                    n_active = 1'b0;
                end
            end else begin
                n_step = r_step + STEP_W'(1);
            end
        end else if (!r_active && !i_qstat.empty) begin
            o_pop    = 1'b1;
            n_job    = i_head;
            n_step   = '0;
            n_active = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        r_job      <= n_job;
        r_out_word <= n_out_word;
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/morse_byte_codec.sv
// top level of the morse byte codec: config register, front end, queue, emitter
//
//  channel  | direction | handshake               | word
//  ---------+-----------+-------------------------+----------------------------------
//  input    | in        | i_in_valid / o_in_ready | i_in_word  {in_byte, end_of_message}
//  output   | out       | o_out_valid/ i_out_ready| o_out_word {out_byte, run_last}
//  config   | in        | psel/penable/pready     | pwdata[0] = mode, paddr 0
//
//  an input word is classified in the cycle it is accepted; a result job goes to a
//  four-entry queue; the emitter sends one output byte per cycle from it unless the
//  output stalls; an encoded character gives separator plus code length bytes, up to
//  7, a decoded token gives 1; the emitter's one byte per cycle sets the sustained
//  rate; a job goes from the queue via the job register into the output register
//  reset is synchronous, active low; no clearing pass is needed
//  the input side stalls only while the queue is full; the output register lets the
//  emitter work ahead of a stalled consumer by one word
`timescale 1ns / 1ps
`include "assert_macros.svh"

module morse_byte_codec #(
    parameter int MAX_CODE_LEN = mbc_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input words
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mbc_pkg::t_in_word           i_in_word,
    // output words
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mbc_pkg::t_out_word          o_out_word,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbc_pkg::PADDR_W-1:0] paddr,
    input  logic [mbc_pkg::PDATA_W-1:0] pwdata,
    output logic [mbc_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    // mode register
    logic r_mode, n_mode;
    logic cfg_wr;
    logic mode_wr;

    // front end to queue
    logic               push;
    mbc_pkg::t_job      push_job;
    // queue to emitter
    logic               pop;
    mbc_pkg::t_job      head;
    mbc_pkg::t_q_status qstat;

    assign pready  = 1'b1;
    // register index is the address bit above the word offset
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign mode_wr = cfg_wr && (paddr[mbc_pkg::PADDR_W-1] == mbc_pkg::REG_IDX_MODE);

    always_comb begin
        n_mode = mode_wr ? pwdata[0] : r_mode;
        if (paddr[mbc_pkg::PADDR_W-1] == mbc_pkg::REG_IDX_MODE) begin
            prdata = {{(mbc_pkg::PDATA_W-1){1'b0}}, r_mode};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mbc_pkg::MODE_ENCODE;
        end else begin
            r_mode <= n_mode;
        end
    end

    // classification and message state; a mode write clears the message
    mbc_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_clear    (mode_wr),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (push_job)
    );

    mbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    // byte serializer with output register
    mbc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_qstat     (qstat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // the front end never writes into a full queue
    `ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, push, !qstat.full)
    // the emitter never pops an empty queue
    `ASSERT_IMPLY(a_no_underflow, i_clk, i_rst_n, pop, !qstat.empty)
    // encoding only ever produces dots, dashes and separators
    `ASSERT_IMPLY(a_enc_alphabet, i_clk, i_rst_n,
        o_out_valid && (r_mode == mbc_pkg::MODE_ENCODE),
        o_out_word.out_byte == mbc_pkg::CH_DOT || o_out_word.out_byte == mbc_pkg::CH_DASH ||
        o_out_word.out_byte == mbc_pkg::CH_SPACE)
    // a decoded character is always the only result of its byte
    `ASSERT_IMPLY(a_dec_single, i_clk, i_rst_n,
        o_out_valid && (r_mode == mbc_pkg::MODE_DECODE), o_out_word.run_last)

endmodule
